// ===== hw/rtl/rlm_pkg.sv =====
// Shared types and constants for the block RMS level meter.
// No dependencies; every module of the meter imports this package.
`timescale 1ns / 1ps

package rlm_pkg;

	localparam int SAMPLE_W        = 16;
	localparam int GAIN_W          = 4;
	localparam int LEVEL_W         = 16;
	localparam int USED_W          = 13;
	localparam int SQR_W           = 31;
	localparam int MAX_SAMPLES_DEF = 4096;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = 4'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 16'hFFFF;

	// Status of the accumulator toward the top-level sequencer.
	typedef struct packed {
		logic done;    // an item has reached the accumulator stage
		logic last;    // that item closed a buffer
	} acc_stat_t;

endpackage

// ===== hw/rtl/block_rms_level_meter.sv =====
// Block RMS level meter: sample stream in, one level per buffer out.
// Uses rlm_pkg, rlm_accum, rlm_root and rlm_out.
//
// Usage:
//   The slave stream carries one audio sample per transfer: tdata[15:0] is the signed
//   sample, tuser marks the sample as present, tlast closes a buffer. A closing transfer
//   produces one master transfer with the RMS level in tdata[15:0] and the number of
//   samples used in tdata[28:16]; an empty buffer reports level 0.
//   The gain register is written through cfg_we/cfg_wdata while the meter is idle; the user
//   must keep to this, as the meter does not enforce it. After each transfer tready drops
//   while the squarer and accumulator run. After a closing transfer the sum and count pass
//   to the divider and then the square root, and tready returns once the result is loaded
//   into the output register. The divider (one quotient bit per cycle) and the square root
//   (one root bit per cycle) share one subtractor.
//   The result sits in an output register; a new buffer can be taken in while it waits.
//   If the receiver still stalls when the next result is ready, the meter holds that
//   result and keeps tready low until the register frees.
//   Reset clears the sums, the count and the output valid, and sets the gain to 3.
`timescale 1ns / 1ps

module block_rms_level_meter #(
	parameter int MAX_SAMPLES = rlm_pkg::MAX_SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [15:0]                 s_axis_tdata,   // sample[15:0]
	input  logic                        s_axis_tuser,   // has_sample
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,   // level[15:0], samples_used[28:16]
	input  logic                        cfg_we,
	input  logic [rlm_pkg::GAIN_W-1:0]  cfg_wdata       // gain
);
	import rlm_pkg::*;

	localparam int SUM_W   = SQR_W + $clog2(MAX_SAMPLES);
	localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
	localparam int SQ_W    = SUM_W + (SUM_W % 2);
	localparam int RT_W    = SQ_W / 2;
	localparam int EXT_W   = (TALLY_W > USED_W) ? TALLY_W : USED_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_ACC    = 3'd1;
	localparam logic [2:0] ST_LAUNCH = 3'd2;
	localparam logic [2:0] ST_ROOT   = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0]         state_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [USED_W-1:0]  used_q;
	logic               take;
	logic               launch;
	logic [SUM_W-1:0]   sum;
	logic [TALLY_W-1:0] tally;
	logic [EXT_W-1:0]   tally_ext;
	acc_stat_t          acc_stat;
	logic               root_done;
	logic [RT_W-1:0]    root;
	logic               out_free;
	logic               out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign take          = s_axis_tvalid && s_axis_tready;
	assign launch        = (state_q == ST_LAUNCH);
	assign out_load      = (state_q == ST_OUT) && out_free;
	assign tally_ext     = EXT_W'(tally);

	rlm_accum #(.MAX_SAMPLES(MAX_SAMPLES)) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.sample ($signed(s_axis_tdata)),
		.has    (s_axis_tuser),
		.last   (s_axis_tlast),
		.clear  (launch),
		.sum    (sum),
		.tally  (tally),
		.stat   (acc_stat)
	);

	rlm_root #(.MAX_SAMPLES(MAX_SAMPLES)) u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (launch),
		.sum    (sum),
		.tally  (tally),
		.done   (root_done),
		.root   (root)
	);

	rlm_out #(.MAX_SAMPLES(MAX_SAMPLES)) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (out_load),
		.root          (root),
		.gain          (gain_q),
		.used          (used_q),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// The count is captured as the accumulator is cleared for the next buffer.
	always_ff @(posedge clk) begin
		if (launch) begin
			used_q <= tally_ext[USED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (acc_stat.done) begin
						state_q <= acc_stat.last ? ST_LAUNCH : ST_IDLE;
					end
				end
				ST_LAUNCH: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/rlm_accum.sv =====
// Squarer and accumulator: keeps the running sum of squares and the sample count.
// Depends on rlm_pkg.
`timescale 1ns / 1ps

module rlm_accum #(
	parameter int MAX_SAMPLES = rlm_pkg::MAX_SAMPLES_DEF,
	localparam int SUM_W   = rlm_pkg::SQR_W + $clog2(MAX_SAMPLES),
	localparam int TALLY_W = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              take,
	input  logic signed [rlm_pkg::SAMPLE_W-1:0] sample,
	input  logic                              has,
	input  logic                              last,
	input  logic                              clear,
	output logic [SUM_W-1:0]                  sum,
	output logic [TALLY_W-1:0]                tally,
	output rlm_pkg::acc_stat_t                stat
);
	import rlm_pkg::*;

	logic                   v_s1, v_s2;
	logic [SAMPLE_W:0]      mag_s1;
	logic                   has_s1, last_s1, has_s2, last_s2;
	logic [SQR_W-1:0]       prod_s2;
	logic [SUM_W-1:0]       sum_q;
	logic [TALLY_W-1:0]     tally_q;
	logic [SAMPLE_W:0]      ext;
	logic [SAMPLE_W:0]      mag;
	logic [2*SAMPLE_W+1:0]  sq;

	// The magnitude of -32768 needs the seventeenth bit.
	assign ext = {sample[SAMPLE_W-1], sample};
	assign mag = ext[SAMPLE_W] ? (~ext + 1'b1) : ext;
	assign sq  = (2*SAMPLE_W+2)'(mag_s1) * (2*SAMPLE_W+2)'(mag_s1);

	always_ff @(posedge clk) begin
		if (take) begin
			mag_s1  <= mag;
			has_s1  <= has;
			last_s1 <= last;
		end
		if (v_s1) begin
			prod_s2 <= sq[SQR_W-1:0];
			has_s2  <= has_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			sum_q   <= '0;
			tally_q <= '0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			if (clear) begin
				sum_q   <= '0;
				tally_q <= '0;
			end else if (v_s2 && has_s2 && (tally_q < TALLY_W'(MAX_SAMPLES))) begin
				sum_q   <= sum_q + SUM_W'(prod_s2);
				tally_q <= TALLY_W'(tally_q + 1'b1);
			end
		end
	end

	assign sum       = sum_q;
	assign tally     = tally_q;
	assign stat.done = v_s2;
	assign stat.last = last_s2;

endmodule

// ===== hw/rtl/rlm_root.sv =====
// Iterative divide and square root on one shared subtractor: isqrt(floor(sum / count)).
// Depends on rlm_pkg.
`timescale 1ns / 1ps

module rlm_root #(
	parameter int MAX_SAMPLES = rlm_pkg::MAX_SAMPLES_DEF,
	localparam int SUM_W   = rlm_pkg::SQR_W + $clog2(MAX_SAMPLES),
	localparam int TALLY_W = $clog2(MAX_SAMPLES + 1),
	localparam int SQ_W    = SUM_W + (SUM_W % 2),
	localparam int RT_W    = SQ_W / 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   sum,
	input  logic [TALLY_W-1:0] tally,
	output logic               done,
	output logic [RT_W-1:0]    root
);
	import rlm_pkg::*;

	localparam int SUB_W = (TALLY_W + 1 > RT_W + 3) ? TALLY_W + 1 : RT_W + 3;
	localparam int CNT_W = $clog2(SQ_W);

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_DIV  = 2'd1;
	localparam logic [1:0] P_SQRT = 2'd2;
	localparam logic [1:0] P_DONE = 2'd3;

	logic [1:0]         phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SQ_W-1:0]    work_q;
	logic [TALLY_W-1:0] div_q;
	logic [SUB_W-1:0]   rem_q;
	logic [RT_W-1:0]    root_q;
	logic [SUB_W-1:0]   op_a, op_b;
	logic [SUB_W:0]     diff;
	logic               ge;

	// The one subtractor serves the divider and the root extraction in turn.
	always_comb begin
		if (phase_q == P_SQRT) begin
			op_a = SUB_W'({rem_q[RT_W:0], work_q[SQ_W-1:SQ_W-2]});
			op_b = SUB_W'({root_q, 2'b01});
		end else begin
			op_a = SUB_W'({rem_q[TALLY_W-1:0], work_q[SQ_W-1]});
			op_b = SUB_W'(div_q);
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = !diff[SUB_W];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= SQ_W'(sum);
			div_q  <= tally;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_W'(SQ_W - 1);
		end else if (phase_q == P_DIV) begin
			// Restoring division: the quotient bits shift in behind the dividend.
			work_q <= {work_q[SQ_W-2:0], ge};
			if (cnt_q == '0) begin
				cnt_q <= CNT_W'(RT_W - 1);
				rem_q <= '0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
				rem_q <= ge ? diff[SUB_W-1:0] : op_a;
			end
		end else if (phase_q == P_SQRT) begin
			work_q <= {work_q[SQ_W-3:0], 2'b00};
			rem_q  <= ge ? diff[SUB_W-1:0] : op_a;
			root_q <= {root_q[RT_W-2:0], ge};
			cnt_q  <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
		end else begin
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						// An empty buffer skips the arithmetic and reports a zero root.
						phase_q <= (tally == '0) ? P_DONE : P_DIV;
					end
				end
				P_DIV: begin
					if (cnt_q == '0) begin
						phase_q <= P_SQRT;
					end
				end
				P_SQRT: begin
					if (cnt_q == '0) begin
						phase_q <= P_DONE;
					end
				end
				P_DONE: begin
					phase_q <= P_IDLE;
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	assign done = (phase_q == P_DONE);
	assign root = root_q;

endmodule

// ===== hw/rtl/rlm_out.sv =====
// Gain scaling, saturation to full scale and the result output register.
// Depends on rlm_pkg.
`timescale 1ns / 1ps

module rlm_out #(
	parameter int MAX_SAMPLES = rlm_pkg::MAX_SAMPLES_DEF,
	localparam int SUM_W = rlm_pkg::SQR_W + $clog2(MAX_SAMPLES),
	localparam int SQ_W  = SUM_W + (SUM_W % 2),
	localparam int RT_W  = SQ_W / 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [RT_W-1:0]             root,
	input  logic [rlm_pkg::GAIN_W-1:0]  gain,
	input  logic [rlm_pkg::USED_W-1:0]  used,
	output logic                        free,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata  // level[15:0], samples_used[28:16]
);
	import rlm_pkg::*;

	localparam int P_W = RT_W + GAIN_W + 1;

	logic               valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic [USED_W-1:0]  used_q;
	logic [P_W-1:0]     prod;
	logic [LEVEL_W-1:0] level;

	// Twice the gain, so the root comes out in Q0.16.
	assign prod  = P_W'(root) * P_W'({gain, 1'b0});
	assign level = (prod > P_W'(LEVEL_MAX)) ? LEVEL_MAX : prod[LEVEL_W-1:0];
	assign free  = !valid_q || m_axis_tready;

	always_ff @(posedge clk) begin
		if (load && free) begin
			level_q <= level;
			used_q  <= used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {3'b000, used_q, level_q};

endmodule

// ===== hw/rtl/rlm_checker.sv =====
// Port-level checks for the block RMS level meter, bound to the top level.
// Depends on block_rms_level_meter.
`timescale 1ns / 1ps

module rlm_checker #(
	parameter int MAX_SAMPLES = rlm_pkg::MAX_SAMPLES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// Each sample occupies the accumulator, so the input closes right after a transfer.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input stayed ready after a sample transfer");

	// A result can never appear in the cycle right after an input transfer.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result appeared directly after an input transfer");

	// An empty buffer must report a zero level.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(MAX_SAMPLES < 8192) && m_axis_tvalid && (m_axis_tdata[28:16] == 13'd0)
		|-> (m_axis_tdata[15:0] == 16'd0))
		else $error("empty buffer gave a nonzero level");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind block_rms_level_meter rlm_checker #(.MAX_SAMPLES(MAX_SAMPLES)) u_rlm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_block_rms_level_meter.sv =====
// Self-checking testbench for block_rms_level_meter: sample buffers go in over the slave
// stream and each level is checked against an in-bench computation of the RMS level.
// Depends on rlm_pkg and the block_rms_level_meter RTL only.
`timescale 1ns / 1ps

module tb_block_rms_level_meter;

	import rlm_pkg::*;

	localparam int CLK_PERIOD  = 20;
	localparam int SETTLE_CYC  = 100;   // margin for a closing transfer to finish
	localparam int LONG_HOLD   = 600;
	localparam int BUF_LIMIT   = MAX_SAMPLES_DEF;

	// Expected levels, in arrival order, plus a model of the meter's running state.
	class level_scoreboard;
		typedef struct {
			logic [LEVEL_W-1:0] level;
			logic [USED_W-1:0]  used;
		} level_rec_t;

		longint             square_sum;
		int unsigned        tally;
		logic [GAIN_W-1:0]  gain;
		level_rec_t         levels_q[$];
		int unsigned        errors;

		function new();
			square_sum = 0;
			tally      = 0;
			gain       = GAIN_RESET;
			errors     = 0;
		endfunction

		function void set_gain(logic [GAIN_W-1:0] g);
			gain = g;
		endfunction

		function int unsigned pending();
			return levels_q.size();
		endfunction

		// Largest r with r*r <= v, one result bit at a time.
		function longint floor_root(longint v);
			longint r;
			longint t;
			r = 0;
			for (int i = 31; i >= 0; i--) begin
				t = r | (longint'(1) << i);
				if (t * t <= v)
					r = t;
			end
			return r;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] smp, logic has, logic last);
			longint     s;
			longint     lvl;
			level_rec_t rec;
			s = longint'($signed(smp));
			if (has && tally < BUF_LIMIT) begin
				square_sum += s * s;
				tally++;
			end
			if (last) begin
				lvl = 0;
				if (tally != 0) begin
					lvl = floor_root(square_sum / longint'(tally)) * 2 * longint'(gain);
					if (lvl > longint'(LEVEL_MAX))
						lvl = longint'(LEVEL_MAX);
				end
				rec.level = lvl[LEVEL_W-1:0];
				rec.used  = tally[USED_W-1:0];
				levels_q.insert(levels_q.size(), rec);
				square_sum = 0;
				tally      = 0;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("tb: mismatch at %0t ns: %s", $time, msg);
		endtask

		task check_level(logic [31:0] word);
			level_rec_t want;
			if (levels_q.size() == 0) begin
				report($sformatf("unexpected level transfer 0x%08h", word));
			end else begin
				want = levels_q.pop_front();
				if (word[15:0] !== want.level)
					report($sformatf("level %0d, expected %0d", word[15:0], want.level));
				if (word[28:16] !== want.used)
					report($sformatf("samples_used %0d, expected %0d",
						word[28:16], want.used));
			end
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [15:0]         s_axis_tdata;   // sample[15:0]
	logic                s_axis_tuser;   // has_sample
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [31:0]         m_axis_tdata;   // level[15:0], samples_used[28:16]
	logic                cfg_we;
	logic [GAIN_W-1:0]   cfg_wdata;      // gain

	level_scoreboard sb;
	logic            no_idle;
	logic            sink_hold_req;

	block_rms_level_meter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		return no_idle ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($signed($urandom_range(0, 128)) - 64);
			default: return 16'($urandom);
		endcase
	endfunction

	// Offers one item and returns at the edge where the transfer happens.
	// Valid stays high into the next item unless that item draws a gap.
	task automatic send_item(input logic [15:0] smp, input logic has, input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= has;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(smp, has, last);
	endtask

	task automatic send_buffer(input int unsigned len, output int unsigned counted);
		logic has;
		counted = 0;
		if (len == 0) begin
			send_item(16'($urandom), 1'b0, 1'b1);
			counted = 1;
		end else begin
			for (int unsigned i = 0; i < len; i++) begin
				has = ($urandom_range(0, 7) != 0);
				send_item(pick_sample(), has, i == len - 1);
				counted++;
			end
		end
	endtask

	task automatic run_phase(input int unsigned n_items);
		int unsigned sent;
		int unsigned got;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 19))
				0:       len = 0;
				1, 2:    len = $urandom_range(9, 40);
				default: len = $urandom_range(1, 8);
			endcase
			send_buffer(len, got);
			sent += got;
		end
	endtask

	// Drops valid, then waits for every outstanding level and for the pipeline to settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_gain(g);
	endtask

	// Result side: draws a stall per transfer; a hold request from the stimulus
	// turns into one long stall so the meter backs up into its input.
	initial begin : level_sink
		int unsigned gap;
		m_axis_tready <= 1'b0;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_level(m_axis_tdata);
				gap = pick_gap();
			end
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				gap = LONG_HOLD;
			end
			if (gap > 0) begin
				gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int unsigned got;
		logic [GAIN_W-1:0] phase_gain [10];
		sb            = new();
		no_idle       = 1'b0;
		sink_hold_req = 1'b0;
		phase_gain    = '{4'd1, 4'd15, 4'd8, 4'd0, 4'd2, 4'd15, 4'd1, 4'd4, 4'd11, 4'd5};
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		s_axis_tlast  <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset gain: empty buffer, extremes, skipped items.
		send_item(16'h1234, 1'b0, 1'b1);
		send_item(16'h8000, 1'b1, 1'b1);
		send_item(16'h7FFF, 1'b1, 1'b1);
		send_item(16'h0000, 1'b1, 1'b1);
		send_item(16'hFFFF, 1'b1, 1'b1);
		send_item(16'h0001, 1'b1, 1'b0);
		send_item(16'hFFFF, 1'b0, 1'b0);
		send_item(16'hFFFF, 1'b1, 1'b0);
		send_item(16'h5555, 1'b0, 1'b1);
		send_item(16'd100, 1'b1, 1'b0);
		send_item(-16'sd200, 1'b1, 1'b0);
		send_item(16'd300, 1'b1, 1'b0);
		send_item(16'h7FFF, 1'b1, 1'b1);
		send_item(16'd1, 1'b1, 1'b1);

		// A gain of zero forces the level to zero.
		write_gain(4'd0);
		send_item(16'h7FFF, 1'b1, 1'b1);
		write_gain(4'd15);
		send_item(16'd1000, 1'b1, 1'b1);
		send_item(16'd3000, 1'b1, 1'b1);
		send_item(16'h8000, 1'b1, 1'b1);

		for (int p = 0; p < 10; p++) begin
			write_gain(phase_gain[p]);
			no_idle = (p == 2 || p == 6);
			if (p == 3) begin
				sink_hold_req = 1'b1;
				for (int b = 0; b < 12; b++)
					send_buffer($urandom_range(1, 3), got);
			end
			run_phase(111);
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
